// ----- hw/rtl/mpw_pkg.sv -----
// Shared types, constants and status codes for the 1553 packet message walker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mpw_pkg;

  // Packet layout constants (bytes)
  localparam int unsigned CHANNEL_WORD_BYTES = 4;
  localparam int unsigned HEADER_BYTES       = 14;
  localparam int unsigned MAX_MESSAGES       = 100000;

  // Field widths
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned INDEX_W  = 17;
  localparam int unsigned WORDS_W  = 6;
  localparam int unsigned CMD_W    = 16;

  // Command word decode constants
  localparam logic [4:0]         SA_MODE_ZERO  = 5'h00;
  localparam logic [4:0]         SA_MODE_ONES  = 5'h1F;
  localparam logic [WORDS_W-1:0] MAX_WORDS     = WORDS_W'(32);
  localparam int unsigned        WC_MODE_BIT   = 4;
  localparam int unsigned        TR_BIT        = 10;

  typedef enum logic {
    FUNC_FIRST = 1'b0,
    FUNC_NEXT  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_OVERRUN = 2'd2
  } status_t;

  // One message header transaction
  typedef struct packed {
    func_t               func;
    logic [COUNT_W-1:0]  message_count;
    logic [OFFSET_W-1:0] data_length;
    logic [LENGTH_W-1:0] msg_length;
    logic                rt_to_rt;
    logic [CMD_W-1:0]    cmd_word_one;
    logic [CMD_W-1:0]    cmd_word_two;
  } item_t;

  // One result transaction
  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  message_index;
    logic [OFFSET_W-1:0] header_offset;
    logic [WORDS_W-1:0]  word_count;
    logic [OFFSET_W-1:0] data_offset;
    logic [OFFSET_W-1:0] status_one_offset;
    logic [OFFSET_W-1:0] status_two_offset;
    logic                has_second_command;
  } result_t;

  // Walker decision handed to the layout logic
  typedef struct packed {
    logic                ok;
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] header_offset;
  } verdict_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mpw_if.sv -----
// Valid/ready channel interfaces for message items and results.
// Depends on mpw_pkg for the payload types.
`default_nettype none

interface mpw_item_if;
  import mpw_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mpw_result_if;
  import mpw_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mpw_walker.sv -----
// Packet walk state and checks: running offset, message number, terminal status.
// Depends on mpw_pkg.
`default_nettype none

module mpw_walker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire mpw_pkg::item_t   item_q,
  output mpw_pkg::verdict_t     verdict
);
  import mpw_pkg::*;

  logic [OFFSET_W-1:0] running_offset, running_offset_next;
  logic [LENGTH_W-1:0] previous_length, previous_length_next;
  logic [COUNT_W-1:0]  packet_count, packet_count_next;
  logic [OFFSET_W-1:0] packet_length, packet_length_next;
  logic [INDEX_W-1:0]  message_number, message_number_next;
  status_t             terminal_status, terminal_status_next;

  // Candidate header offset: fixed after the channel word, or advance past the last message
  logic [OFFSET_W:0]   offset;
  logic [OFFSET_W+1:0] msg_end;

  always_comb begin
    if (item_q.func == FUNC_FIRST) begin
      offset = (OFFSET_W+1)'(CHANNEL_WORD_BYTES);
    end else begin
      offset = {1'b0, running_offset} + (OFFSET_W+1)'(HEADER_BYTES)
             + (OFFSET_W+1)'(previous_length);
    end
    msg_end = {1'b0, offset} + (OFFSET_W+2)'(HEADER_BYTES)
            + (OFFSET_W+2)'(item_q.msg_length);
  end

  // Checks and next state
  always_comb begin
    logic do_check;
    do_check             = 1'b0;
    running_offset_next  = running_offset;
    previous_length_next = previous_length;
    packet_count_next    = packet_count;
    packet_length_next   = packet_length;
    message_number_next  = message_number;
    terminal_status_next = terminal_status;
    verdict.ok            = 1'b0;
    verdict.status        = terminal_status;
    verdict.header_offset = offset[OFFSET_W-1:0];

    if (item_q.func == FUNC_FIRST) begin
      terminal_status_next = ST_OK;
      message_number_next  = '0;
      packet_count_next    = item_q.message_count;
      packet_length_next   = item_q.data_length;
      if (item_q.message_count == '0) begin
        verdict.status = ST_NO_DATA;
      end else if (item_q.message_count > COUNT_W'(MAX_MESSAGES)) begin
        verdict.status = ST_OVERRUN;
      end else begin
        do_check = 1'b1;
      end
    end else if (terminal_status != ST_OK) begin
      // Terminal: repeat status, state untouched
      verdict.status = terminal_status;
    end else begin
      if (message_number != '1) begin
        message_number_next = message_number + INDEX_W'(1);
      end
      if (COUNT_W'(message_number_next) >= packet_count) begin
        verdict.status = ST_NO_DATA;
      end else begin
        do_check = 1'b1;
      end
    end

    if (do_check) begin
      running_offset_next = offset[OFFSET_W-1:0];
      if (offset >= (OFFSET_W+1)'(packet_length_next) ||
          msg_end > (OFFSET_W+2)'(packet_length_next)) begin
        verdict.status = ST_OVERRUN;
      end else begin
        verdict.ok           = 1'b1;
        verdict.status       = ST_OK;
        previous_length_next = item_q.msg_length;
      end
    end

    // A failure on this transaction becomes the terminal status
    if (!verdict.ok && !(item_q.func == FUNC_NEXT && terminal_status != ST_OK)) begin
      terminal_status_next = verdict.status;
    end
    verdict.index = message_number_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_offset  <= '0;
      previous_length <= '0;
      packet_count    <= '0;
      packet_length   <= '0;
      message_number  <= '0;
      terminal_status <= ST_OK;
    end else if (step) begin
      running_offset  <= running_offset_next;
      previous_length <= previous_length_next;
      packet_count    <= packet_count_next;
      packet_length   <= packet_length_next;
      message_number  <= message_number_next;
      terminal_status <= terminal_status_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpw_layout.sv -----
// Word offset layout of one 1553 message: data and status words, word count.
// Depends on mpw_pkg.
`default_nettype none

module mpw_layout (
  input  wire mpw_pkg::verdict_t verdict,
  input  wire logic              rt_to_rt,
  input  wire logic [15:0]       cmd_word_one,
  input  wire logic [15:0]       cmd_word_two,
  output mpw_pkg::result_t       result
);
  import mpw_pkg::*;

  // Data word count with the mode code rule
  function automatic logic [WORDS_W-1:0] words_of(input logic [CMD_W-1:0] cw);
    logic [4:0] sub;
    logic [4:0] cnt;
    sub = cw[9:5];
    cnt = cw[4:0];
    if (sub == SA_MODE_ZERO || sub == SA_MODE_ONES) begin
      return WORDS_W'(cnt[WC_MODE_BIT]);
    end else if (cnt == '0) begin
      return MAX_WORDS;
    end else begin
      return WORDS_W'(cnt);
    end
  endfunction

  logic [WORDS_W-1:0]  wc;
  logic [OFFSET_W:0]   cmd1, data, st1, st2;

  always_comb begin
    cmd1 = (OFFSET_W+1)'(verdict.header_offset) + (OFFSET_W+1)'(HEADER_BYTES);
    st2  = '0;
    if (!rt_to_rt) begin
      wc = words_of(cmd_word_one);
      if (!cmd_word_one[TR_BIT]) begin
        // Receive: command, data, status
        data = cmd1 + (OFFSET_W+1)'(2);
        st1  = data + (OFFSET_W+1)'({wc, 1'b0});
      end else begin
        // Transmit: command, status, data
        st1  = cmd1 + (OFFSET_W+1)'(2);
        data = cmd1 + (OFFSET_W+1)'(4);
      end
    end else begin
      // RT-to-RT: command one, command two, status two, data, status one
      wc   = words_of(cmd_word_two);
      st2  = cmd1 + (OFFSET_W+1)'(4);
      data = cmd1 + (OFFSET_W+1)'(6);
      st1  = data + (OFFSET_W+1)'({wc, 1'b0});
    end
  end

  // Failures carry only status and index
  always_comb begin
    result               = '0;
    result.status        = verdict.status;
    result.message_index = verdict.index;
    if (verdict.ok) begin
      result.header_offset      = verdict.header_offset;
      result.word_count         = wc;
      result.data_offset        = data[OFFSET_W-1:0];
      result.status_one_offset  = st1[OFFSET_W-1:0];
      result.status_two_offset  = st2[OFFSET_W-1:0];
      result.has_second_command = rt_to_rt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mil1553_packet_message_walker.sv -----
// MIL-STD-1553 packet message walker, top level.
// Depends on mpw_pkg, mpw_if, mpw_walker and mpw_layout.
//
// Usage:
//   item   - valid/ready channel of message headers. A transaction with func
//            FUNC_FIRST starts a packet and brings its message count and data
//            length; FUNC_NEXT transactions walk the following messages.
//   result - valid/ready channel with one result per item: status, message
//            index, header offset, data and status word offsets, word count.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while result is not held; the walk state
//   (offset, length, message number) updates in the same cycle the item
//   leaves the input register, so the next item sees it immediately.
// Reset: rst (synchronous) clears the walk state, so a next item before any
//   first item reports no more data. Both pipeline registers empty.
// Stall: when result is held (valid and not ready) both stages freeze and
//   item.ready falls once the input register is full; nothing is dropped.
`default_nettype none

module mil1553_packet_message_walker (
  input  wire logic       clk,
  input  wire logic       rst,
  mpw_item_if.sink        item,
  mpw_result_if.source    result
);
  import mpw_pkg::*;

  logic     s1_valid;
  item_t    s1_item;
  logic     advance;
  verdict_t verdict;
  result_t  result_d;

  assign advance    = !result.valid || result.ready;
  assign item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_item <= item.payload;
    end
  end

  mpw_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (advance && s1_valid),
    .item_q  (s1_item),
    .verdict (verdict)
  );

  mpw_layout u_layout (
    .verdict      (verdict),
    .rt_to_rt     (s1_item.rt_to_rt),
    .cmd_word_one (s1_item.cmd_word_one),
    .cmd_word_two (s1_item.cmd_word_two),
    .result       (result_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result.payload <= result_d;
    end
  end

endmodule

`default_nettype wire

// ----- test/mpw_checker.sv -----
// Checker for the 1553 packet message walker: watches both channels, predicts each
// result from the accepted message headers and compares field by field.
// Depends on mpw_pkg and mpw_if.
`timescale 1ns / 1ps

module mpw_checker (
  input  logic        clk,
  input  logic        rst,
  mpw_item_if         item,
  mpw_result_if       result,
  output int unsigned mismatches,
  output int unsigned layouts_due
);
  import mpw_pkg::*;

  // Predicted walk state
  logic [OFFSET_W-1:0] walk_offset;
  logic [LENGTH_W-1:0] last_length;
  logic [COUNT_W-1:0]  pkt_msgs;
  logic [OFFSET_W-1:0] pkt_bytes;
  logic [INDEX_W-1:0]  msg_num;
  status_t             sticky_status;

  result_t predicted_layouts[$];

  initial begin
    mismatches  = 0;
    layouts_due = 0;
  end

  // Data word count of one command word, mode codes included
  function automatic logic [WORDS_W-1:0] data_words(input logic [CMD_W-1:0] cw);
    logic [4:0] sa;
    logic [4:0] cnt;
    sa  = cw[9:5];
    cnt = cw[4:0];
    if (sa == SA_MODE_ZERO || sa == SA_MODE_ONES)
      return cnt[WC_MODE_BIT] ? WORDS_W'(1) : '0;
    if (cnt == 5'd0)
      return MAX_WORDS;
    return WORDS_W'(cnt);
  endfunction

  // Advance the walk by one message header and lay out its words
  function automatic result_t walk_message(input item_t it);
    result_t            r;
    status_t            st;
    logic [31:0]        off;
    logic [31:0]        cmd1;
    logic [31:0]        dat;
    logic [31:0]        st1;
    logic [31:0]        st2;
    logic [WORDS_W-1:0] wc;
    r   = '0;
    st  = ST_OK;
    off = '0;
    if (it.func == FUNC_FIRST) begin
      sticky_status = ST_OK;
      msg_num       = '0;
      pkt_msgs      = it.message_count;
      pkt_bytes     = it.data_length;
      if (pkt_msgs == '0)
        st = ST_NO_DATA;
      else if (32'(pkt_msgs) > MAX_MESSAGES)
        st = ST_OVERRUN;
      off = CHANNEL_WORD_BYTES;
    end else if (sticky_status != ST_OK) begin
      // once a packet has ended, next items just repeat the verdict
      r.status        = sticky_status;
      r.message_index = msg_num;
      return r;
    end else begin
      if (msg_num != '1)
        msg_num = msg_num + 1'b1;
      if (32'(msg_num) >= 32'(pkt_msgs))
        st = ST_NO_DATA;
      off = 32'(walk_offset) + HEADER_BYTES + 32'(last_length);
    end

    // bounds against the packet data length, unwrapped
    if (st == ST_OK) begin
      walk_offset = off[OFFSET_W-1:0];
      if (off >= 32'(pkt_bytes) || off + HEADER_BYTES + 32'(it.msg_length) > 32'(pkt_bytes))
        st = ST_OVERRUN;
    end
    r.message_index = msg_num;
    if (st != ST_OK) begin
      sticky_status = st;
      r.status      = st;
      return r;
    end
    last_length = it.msg_length;

    // word layout after the intra-packet header
    cmd1 = off + HEADER_BYTES;
    st2  = '0;
    if (!it.rt_to_rt) begin
      wc = data_words(it.cmd_word_one);
      if (!it.cmd_word_one[TR_BIT]) begin
        dat = cmd1 + 2;
        st1 = dat + 2 * 32'(wc);
      end else begin
        st1 = cmd1 + 2;
        dat = cmd1 + 4;
      end
    end else begin
      wc  = data_words(it.cmd_word_two);
      st2 = cmd1 + 4;
      dat = cmd1 + 6;
      st1 = dat + 2 * 32'(wc);
      r.has_second_command = 1'b1;
    end
    r.status            = ST_OK;
    r.header_offset     = off[OFFSET_W-1:0];
    r.word_count        = wc;
    r.data_offset       = dat[OFFSET_W-1:0];
    r.status_one_offset = st1[OFFSET_W-1:0];
    r.status_two_offset = st2[OFFSET_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] result mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, field, got, want);
  endtask

  // Compare accepted results, then predict for accepted headers
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      walk_offset   = '0;
      last_length   = '0;
      pkt_msgs      = '0;
      pkt_bytes     = '0;
      msg_num       = '0;
      sticky_status = ST_OK;
      predicted_layouts.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = result.payload;
        if (predicted_layouts.size() == 0) begin
          report_mismatch("unpredicted transaction", 32'(got.status), 32'(0));
        end else begin
          want = predicted_layouts.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.message_index != want.message_index)
            report_mismatch("message_index", 32'(got.message_index), 32'(want.message_index));
          if (got.header_offset != want.header_offset)
            report_mismatch("header_offset", 32'(got.header_offset), 32'(want.header_offset));
          if (got.word_count != want.word_count)
            report_mismatch("word_count", 32'(got.word_count), 32'(want.word_count));
          if (got.data_offset != want.data_offset)
            report_mismatch("data_offset", 32'(got.data_offset), 32'(want.data_offset));
          if (got.status_one_offset != want.status_one_offset)
            report_mismatch("status_one_offset", 32'(got.status_one_offset),
                            32'(want.status_one_offset));
          if (got.status_two_offset != want.status_two_offset)
            report_mismatch("status_two_offset", 32'(got.status_two_offset),
                            32'(want.status_two_offset));
          if (got.has_second_command != want.has_second_command)
            report_mismatch("has_second_command", 32'(got.has_second_command),
                            32'(want.has_second_command));
        end
      end
      if (item.valid && item.ready)
        predicted_layouts.push_back(walk_message(item.payload));
    end
    layouts_due = predicted_layouts.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the 1553 packet message walker: clock, reset, header stimulus,
// result back-pressure and the verdict. Depends on mpw_pkg, mpw_if, mpw_checker
// and the walker RTL.
`timescale 1ns / 1ps

module tb_top;
  import mpw_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned ITEM_GOAL  = 700;

  // Command words covering receive, transmit, both mode subaddresses and zero count
  localparam logic [CMD_W-1:0] CMD_SET [8] = '{
    16'h0820, 16'h0C45, 16'h0010, 16'h03EF, 16'h07FF, 16'hFFFF, 16'h0000, 16'hFBDF
  };

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned layouts_due;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;
  bit          no_gaps     = 1'b0;
  bit          stall_request = 1'b0;

  mpw_item_if   item_ch ();
  mpw_result_if result_ch ();

  mil1553_packet_message_walker u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  mpw_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .mismatches  (fail_count),
    .layouts_due (layouts_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t make_item(input func_t f, input logic [COUNT_W-1:0] cnt,
                                      input logic [OFFSET_W-1:0] dlen,
                                      input logic [LENGTH_W-1:0] mlen, input logic rt,
                                      input logic [CMD_W-1:0] cw1,
                                      input logic [CMD_W-1:0] cw2);
    item_t it;
    it.func          = f;
    it.message_count = cnt;
    it.data_length   = dlen;
    it.msg_length    = mlen;
    it.rt_to_rt      = rt;
    it.cmd_word_one  = cw1;
    it.cmd_word_two  = cw2;
    return it;
  endfunction

  // Random command word, biased toward mode code subaddresses
  function automatic logic [CMD_W-1:0] rand_cmd();
    logic [CMD_W-1:0] cw;
    cw = CMD_W'($urandom);
    if ($urandom_range(0, 3) == 0)
      cw[9:5] = ($urandom_range(0, 1) == 1) ? SA_MODE_ONES : SA_MODE_ZERO;
    return cw;
  endfunction

  // Offer one transaction; called and left at a falling edge
  task automatic push_item(input item_t it);
    int unsigned gap;
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    @(negedge clk);
    gap = no_gaps ? 0 : draw_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (layouts_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One packet: mostly well formed, sometimes broken or plain noise
  task automatic send_packet(input bit gapless);
    int unsigned         n;
    int unsigned         kind;
    int unsigned         extra;
    int unsigned         cut;
    logic [31:0]         need;
    logic [31:0]         dlen;
    logic [31:0]         cnt;
    logic [LENGTH_W-1:0] lens[$];
    logic [LENGTH_W-1:0] len;
    no_gaps = gapless || ($urandom_range(0, 4) == 0);
    kind    = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 4))
        push_item(make_item(func_t'($urandom_range(0, 1)), COUNT_W'($urandom),
                            OFFSET_W'($urandom), LENGTH_W'($urandom),
                            1'($urandom_range(0, 1)), rand_cmd(), CMD_W'($urandom)));
      return;
    end
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    need = CHANNEL_WORD_BYTES;
    repeat (n) begin
      len = ($urandom_range(0, 49) == 0) ? LENGTH_W'($urandom_range(1000, 65535))
                                         : LENGTH_W'($urandom_range(0, 80));
      if (need + HEADER_BYTES + len > 32'hF0000)
        len = LENGTH_W'($urandom_range(0, 80));
      lens.push_back(len);
      need = need + HEADER_BYTES + len;
    end
    dlen = need + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40));
    cnt  = n;
    if (kind < 10) begin
      cnt = n + $urandom_range(1, 3);
    end else if (kind < 20) begin
      cnt = $urandom_range(1, n);
    end else if (kind >= 89) begin
      cnt = 0;
    end else if (kind >= 86) begin
      cnt = $urandom_range(MAX_MESSAGES + 1, 24'hFFFFFF);
    end else if (kind >= 80) begin
      // data length a little short, so a late message runs past it
      cut  = $urandom_range(1, 20);
      dlen = (need > cut) ? need - cut : 0;
    end
    if (dlen > 32'hFFFFF)
      dlen = 32'hFFFFF;
    foreach (lens[k])
      push_item(make_item((k == 0) ? FUNC_FIRST : FUNC_NEXT,
                          (k == 0) ? COUNT_W'(cnt) : COUNT_W'($urandom),
                          (k == 0) ? OFFSET_W'(dlen) : OFFSET_W'($urandom),
                          lens[k], 1'($urandom_range(0, 3) == 0), rand_cmd(), rand_cmd()));
    // a few next items past the end of the packet
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (extra)
      push_item(make_item(FUNC_NEXT, COUNT_W'($urandom), OFFSET_W'($urandom),
                          LENGTH_W'($urandom), 1'($urandom_range(0, 1)), rand_cmd(),
                          rand_cmd()));
  endtask

  // Result side: random holds, ready streaks, and the long hold on request
  initial begin : result_sink
    int unsigned hold;
    int unsigned streak;
    int unsigned gap;
    hold   = 0;
    streak = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold          = LONG_HOLD;
      end
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else if (streak > 0) begin
        result_ch.ready <= 1'b1;
        streak--;
      end else if ($urandom_range(0, 19) == 0) begin
        result_ch.ready <= 1'b1;
        streak = $urandom_range(20, 100);
      end else begin
        gap = draw_gap();
        if (gap == 0) begin
          result_ch.ready <= 1'b1;
        end else begin
          result_ch.ready <= 1'b0;
          hold = gap - 1;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin : header_source
    int                  k;
    logic [LENGTH_W-1:0] len;
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // next before any first, then a repeat of that verdict
    push_item(make_item(FUNC_NEXT, '0, '0, '0, 1'b0, '0, '0));
    push_item(make_item(FUNC_NEXT, '1, '1, '1, 1'b1, '1, '1));
    // zero count, count just over the limit, count at its field maximum
    push_item(make_item(FUNC_FIRST, '0, OFFSET_W'(100), LENGTH_W'(2), 1'b0, '0, '0));
    push_item(make_item(FUNC_FIRST, COUNT_W'(MAX_MESSAGES + 1), OFFSET_W'(1000),
                        LENGTH_W'(10), 1'b0, CMD_SET[0], '0));
    push_item(make_item(FUNC_FIRST, '1, '1, '1, 1'b1, '1, '1));
    // header start at an empty data length
    push_item(make_item(FUNC_FIRST, COUNT_W'(MAX_MESSAGES), '0, '0, 1'b0, CMD_SET[1], '0));
    // one long message, then the count runs out
    push_item(make_item(FUNC_FIRST, COUNT_W'(1), OFFSET_W'(524288), '1, 1'b0, '1, '0));
    push_item(make_item(FUNC_NEXT, COUNT_W'(1), '0, '0, 1'b0, '0, '0));
    // first message runs past the data
    push_item(make_item(FUNC_FIRST, COUNT_W'(2), OFFSET_W'(20), LENGTH_W'(3), 1'b0,
                        CMD_SET[2], '0));
    // maximal packet whose last message puts word offsets past 20 bits
    for (k = 0; k < 17; k++) begin
      len = (k < 15) ? 16'hFFFF : ((k == 15) ? 16'd65308 : 16'd0);
      push_item(make_item((k == 0) ? FUNC_FIRST : FUNC_NEXT, COUNT_W'(17), '1, len,
                          k[0] | (k == 16), CMD_SET[k % 8],
                          (k == 16) ? CMD_SET[0] : CMD_SET[(k + 3) % 8]));
    end
    drain_results();

    // long receiver hold while headers keep coming
    stall_request = 1'b1;
    repeat (5) send_packet(1'b1);
    drain_results();

    while (items_sent < ITEM_GOAL) begin
      send_packet(1'b0);
      if ($urandom_range(0, 29) == 0)
        drain_results();
    end
    drain_results();

    if (fail_count == 0 && layouts_due == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
